// ----- src/ltrk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the 2^(-i/16) table for the product kernel block.
// No dependencies; every other file uses it through scoped names.
package ltrk_pkg;

    localparam int ElemW    = 16;
    localparam int DotW     = 42;
    localparam int DistW    = 41;
    localparam int CfgIdxW  = 2;
    localparam int KvW      = 32;

    localparam logic [ElemW-1:0] OffsetRst = 16'h0000;
    localparam logic [ElemW-1:0] ScaleRst  = 16'h0100;
    localparam logic [ElemW-1:0] InvRst    = 16'h0080;

    // Exponent argument at or above 12.0 (Q.16) gives zero.
    localparam logic [19:0] ExpCutoff = 20'd786432;
    // log2(e) in Q.16.
    localparam logic [16:0] Log2eQ16  = 17'd94548;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OFFSET       = 2'd0,
        REG_SCALE        = 2'd1,
        REG_INV_TWO_M_SQ = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_MUL_D,
        ST_ARG,
        ST_LOG,
        ST_INTERP,
        ST_SHIFT,
        ST_MUL_M,
        ST_SUM_M,
        ST_MUL_S,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic ld_d;
        logic ld_arg;
        logic ld_t;
        logic ld_v;
        logic ld_e;
        logic ld_mp;
        logic ld_m1;
        logic ld_sp;
        logic ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // 2^(-i/16) in Q1.16 for i = 0..16.
    function automatic logic [16:0] pow2_neg(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ----- src/ltrk_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input words, result words and register writes.
// Depends on ltrk_pkg for field widths.
interface ltrk_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ltrk_pkg::ElemW-1:0]   x_elem;
    logic signed [ltrk_pkg::ElemW-1:0]   y_elem;
    logic signed [ltrk_pkg::ElemW-1:0]   p_elem;
    logic signed [ltrk_pkg::ElemW-1:0]   q_elem;
    logic                                last;
    modport source (output valid, x_elem, y_elem, p_elem, q_elem, last, input ready);
    modport sink   (input valid, x_elem, y_elem, p_elem, q_elem, last, output ready);
endinterface

interface ltrk_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ltrk_pkg::KvW-1:0]   kernel_value;
    logic                              saturated;
    modport source (output valid, kernel_value, saturated, input ready);
    modport sink   (input valid, kernel_value, saturated, output ready);
endinterface

interface ltrk_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ltrk_pkg::CfgIdxW-1:0]      index;
    logic [ltrk_pkg::ElemW-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ltrk_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: accumulate state, then a fixed sequence of back-end steps per pair.
// Depends on ltrk_pkg for the state enum and the command/status structs.
module ltrk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last,
    input  ltrk_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output ltrk_pkg::t_dp_cmd  o_cmd
);

    ltrk_pkg::t_state r_state;
    ltrk_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltrk_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltrk_pkg::ST_ACC: begin
                if (i_in_valid && i_last) begin
                    n_state = ltrk_pkg::ST_MUL_D;
                end
            end
            ltrk_pkg::ST_MUL_D:  n_state = ltrk_pkg::ST_ARG;
            ltrk_pkg::ST_ARG:    n_state = ltrk_pkg::ST_LOG;
            ltrk_pkg::ST_LOG:    n_state = ltrk_pkg::ST_INTERP;
            ltrk_pkg::ST_INTERP: n_state = ltrk_pkg::ST_SHIFT;
            ltrk_pkg::ST_SHIFT:  n_state = ltrk_pkg::ST_MUL_M;
            ltrk_pkg::ST_MUL_M:  n_state = ltrk_pkg::ST_SUM_M;
            ltrk_pkg::ST_SUM_M:  n_state = ltrk_pkg::ST_MUL_S;
            ltrk_pkg::ST_MUL_S:  n_state = ltrk_pkg::ST_DONE;
            ltrk_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ltrk_pkg::ST_ACC;
                end
            end
            default:             n_state = ltrk_pkg::ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ltrk_pkg::ST_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
            end
            ltrk_pkg::ST_MUL_D:  o_cmd.ld_d   = 1'b1;
            ltrk_pkg::ST_ARG:    o_cmd.ld_arg = 1'b1;
            ltrk_pkg::ST_LOG:    o_cmd.ld_t   = 1'b1;
            ltrk_pkg::ST_INTERP: o_cmd.ld_v   = 1'b1;
            ltrk_pkg::ST_SHIFT:  o_cmd.ld_e   = 1'b1;
            ltrk_pkg::ST_MUL_M:  o_cmd.ld_mp  = 1'b1;
            ltrk_pkg::ST_SUM_M:  o_cmd.ld_m1  = 1'b1;
            ltrk_pkg::ST_MUL_S:  o_cmd.ld_sp  = 1'b1;
            ltrk_pkg::ST_DONE:   o_cmd.ld_out = i_stat.out_free;
            default:             o_cmd        = '0;
        endcase
    end

    // Only one datapath step is commanded in any cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    // A word with last set always starts the back-end sequence.
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_last) |=> (r_state == ltrk_pkg::ST_MUL_D))
        else $error("last word did not start the back end");

    // Once the result register is free, the final step hands control back to input.
    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ltrk_pkg::ST_DONE && i_stat.out_free) |=> (r_state == ltrk_pkg::ST_ACC))
        else $error("back end did not return to accumulation");

endmodule

// ----- src/ltrk_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: registers, accumulators, exponential and final products, result register.
// Depends on ltrk_pkg for widths, table, register codes and command/status structs.
module ltrk_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ltrk_pkg::t_dp_cmd                    i_cmd,
    output ltrk_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_cfg_we,
    input  logic [ltrk_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [ltrk_pkg::ElemW-1:0]           i_cfg_data,
    input  logic signed [ltrk_pkg::ElemW-1:0]    i_x_elem,
    input  logic signed [ltrk_pkg::ElemW-1:0]    i_y_elem,
    input  logic signed [ltrk_pkg::ElemW-1:0]    i_p_elem,
    input  logic signed [ltrk_pkg::ElemW-1:0]    i_q_elem,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [ltrk_pkg::KvW-1:0]      o_kernel_value,
    output logic                                 o_saturated
);

    localparam int EW = ltrk_pkg::ElemW;
    localparam int DW = ltrk_pkg::DotW;
    localparam int SW = ltrk_pkg::DistW;

    logic signed [EW-1:0] r_offset;
    logic signed [EW-1:0] r_scale;
    logic [EW-1:0]        r_inv;

    logic signed [DW-1:0] r_dot_acc;
    logic [SW-1:0]        r_dist_acc;

    logic [39:0] r_pl;
    logic [32:0] r_ph;
    logic [41:0] r_mag;
    logic        r_neg;
    logic [31:0] r_s2;
    logic [19:0] r_arg;
    logic        r_cut;
    logic [20:0] r_t;
    logic [16:0] r_v;
    logic [15:0] r_e;
    logic [36:0] r_mpl;
    logic [36:0] r_mph;
    logic [41:0] r_m1;
    logic [52:0] r_spl;
    logic [52:0] r_sph;
    logic        r_out_valid;
    logic [31:0] r_kv;
    logic        r_sat;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= ltrk_pkg::OffsetRst;
            r_scale  <= ltrk_pkg::ScaleRst;
            r_inv    <= ltrk_pkg::InvRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ltrk_pkg::REG_OFFSET:       r_offset <= i_cfg_data;
                ltrk_pkg::REG_SCALE:        r_scale  <= i_cfg_data;
                ltrk_pkg::REG_INV_TWO_M_SQ: r_inv    <= i_cfg_data;
                default:                    ;
            endcase
        end
    end

    // Per-word accumulation with saturation at the accumulator widths.
    logic signed [16:0] w_dx, w_dy, w_dpq;
    logic signed [33:0] w_prod, w_sq_s;
    logic [32:0]        w_sq;
    logic [42:0]        w_dot_sum;
    logic [41:0]        w_dist_sum;
    logic [DW-1:0]      w_dot_next;
    logic [SW-1:0]      w_dist_next;

    assign w_dx   = {i_x_elem[EW-1], i_x_elem} - {r_offset[EW-1], r_offset};
    assign w_dy   = {i_y_elem[EW-1], i_y_elem} - {r_offset[EW-1], r_offset};
    assign w_dpq  = {i_p_elem[EW-1], i_p_elem} - {i_q_elem[EW-1], i_q_elem};
    assign w_prod = w_dx * w_dy;
    assign w_sq_s = w_dpq * w_dpq;
    assign w_sq   = w_sq_s[32:0];
    assign w_dot_sum  = {r_dot_acc[DW-1], r_dot_acc} + {{9{w_prod[33]}}, w_prod};
    assign w_dist_sum = {1'b0, r_dist_acc} + {9'd0, w_sq};

    always_comb begin
        if (w_dot_sum[42] != w_dot_sum[41]) begin
            w_dot_next = w_dot_sum[42] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            w_dot_next = w_dot_sum[DW-1:0];
        end
        w_dist_next = w_dist_sum[41] ? {SW{1'b1}} : w_dist_sum[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_acc  <= '0;
            r_dist_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_dot_acc  <= w_dot_next;
            r_dist_acc <= w_dist_next;
        end else if (i_cmd.ld_d) begin
            r_dot_acc  <= '0;
            r_dist_acc <= '0;
        end
    end

    // Back-end combinational terms, one step per command.
    logic [39:0]        w_pl;
    logic [32:0]        w_ph;
    logic [41:0]        w_mag;
    logic signed [31:0] w_s2;
    logic [56:0]        w_full;
    logic [48:0]        w_arg;
    logic [37:0]        w_tp;
    logic [16:0]        w_ta, w_tb, w_diff, w_v;
    logic [23:0]        w_dw;
    logic [23:0]        w_dr;
    logic [4:0]         w_n;
    logic [18:0]        w_rs;
    logic [36:0]        w_mpl, w_mph;
    logic [58:0]        w_ms;
    logic [52:0]        w_spl, w_sph;
    logic [74:0]        w_ss;
    logic [58:0]        w_r;
    logic               w_sat;
    logic [31:0]        w_kv;

    assign w_pl   = r_dist_acc[23:0] * r_inv;
    assign w_ph   = r_dist_acc[SW-1:24] * r_inv;
    assign w_mag  = r_dot_acc[DW-1] ? (42'd0 - r_dot_acc) : r_dot_acc;
    assign w_s2   = r_scale * r_scale;
    assign w_full = {r_ph, 24'd0} + {17'd0, r_pl};
    assign w_arg  = w_full[56:8];
    assign w_tp   = r_arg * ltrk_pkg::Log2eQ16 + 38'd32768;
    assign w_ta   = ltrk_pkg::pow2_neg({1'b0, r_t[15:12]});
    assign w_tb   = ltrk_pkg::pow2_neg({1'b0, r_t[15:12]} + 5'd1);
    assign w_diff = w_ta - w_tb;
    assign w_dw   = w_diff[11:0] * r_t[11:0];
    assign w_dr   = w_dw + 24'd2048;
    assign w_v    = w_ta - {5'd0, w_dr[23:12]};
    assign w_n    = r_t[20:16];
    // (2v + 2^n) >> (n+1) rounds v / 2^n half up, and leaves v unchanged for n = 0.
    assign w_rs   = ({1'b0, r_v, 1'b0} + (19'd1 << w_n)) >> (w_n + 5'd1);
    assign w_mpl  = r_mag[20:0] * r_e;
    assign w_mph  = r_mag[41:21] * r_e;
    assign w_ms   = {1'b0, r_mph, 21'd0} + {22'd0, r_mpl} + 59'd32768;
    assign w_spl  = r_m1[20:0] * r_s2;
    assign w_sph  = r_m1[41:21] * r_s2;
    assign w_ss   = {1'b0, r_sph, 21'd0} + {22'd0, r_spl} + 75'd32768;
    assign w_r    = w_ss[74:16];
    assign w_sat  = r_neg ? (w_r > 59'h0_8000_0000) : (w_r > 59'h0_7FFF_FFFF);

    always_comb begin
        if (w_sat) begin
            w_kv = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_kv = r_neg ? (32'd0 - w_r[31:0]) : w_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_d) begin
            r_pl  <= w_pl;
            r_ph  <= w_ph;
            r_mag <= w_mag;
            r_neg <= r_dot_acc[DW-1];
            r_s2  <= w_s2;
        end
        if (i_cmd.ld_arg) begin
            r_arg <= w_arg[19:0];
            r_cut <= (w_arg[48:20] != '0) || (w_arg[19:0] >= ltrk_pkg::ExpCutoff);
        end
        if (i_cmd.ld_t) begin
            r_t <= w_tp[36:16];
        end
        if (i_cmd.ld_v) begin
            r_v <= w_v;
        end
        if (i_cmd.ld_e) begin
            if (r_cut) begin
                r_e <= '0;
            end else if (w_rs > 19'd65535) begin
                r_e <= 16'hFFFF;
            end else begin
                r_e <= w_rs[15:0];
            end
        end
        if (i_cmd.ld_mp) begin
            r_mpl <= w_mpl;
            r_mph <= w_mph;
        end
        if (i_cmd.ld_m1) begin
            r_m1 <= w_ms[57:16];
        end
        if (i_cmd.ld_sp) begin
            r_spl <= w_spl;
            r_sph <= w_sph;
        end
        if (i_cmd.ld_out) begin
            r_kv  <= w_kv;
            r_sat <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_kernel_value  = r_kv;
    assign o_saturated     = r_sat;

    // Both accumulators are empty once a pair has been handed to the back end.
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_d |=> (r_dot_acc == '0) && (r_dist_acc == '0))
        else $error("accumulators not cleared after a pair");

    // A clipped result carries one of the two limit values.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |-> ((r_kv == 32'h7FFF_FFFF) || (r_kv == 32'h8000_0000)))
        else $error("saturated flag without a limit value");

    // An argument past the cutoff yields a zero exponential.
    a_cut_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_e && r_cut) |=> (r_e == '0))
        else $error("exponential not zero beyond cutoff");

    // A new result is only loaded when the result register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

// ----- src/linear_times_rbf_kernel_top.sv -----
`timescale 1ns / 1ps
// Top level of the linear-times-squared-exponential product kernel.
// Depends on ltrk_pkg, the channel interfaces, ltrk_ctrl and ltrk_datapath.
//
//   Channel  Direction  Payload                                   Word accepted when
//   i_in     in         x_elem, y_elem, p_elem, q_elem, last      valid && ready
//   o_out    out        kernel_value, saturated                   valid && ready
//   i_cfg    in         index (0 offset, 1 scale, 2 inv_two_m_sq), data   valid && ready
//
// Cycles: element words are taken one per cycle while the accumulators run. The word
// that carries last starts the back-end sequence (split multiplies for the exponent
// argument, log2 scaling, table interpolation, rounding shift, and two split product
// steps); ready stays low through it, so no word of the next pair is taken meanwhile.
// The final back-end step loads the result into the output register.
// Reset is synchronous and active low; it restores register defaults and clears the
// accumulators. A stalled result holds in the output register, and the back end waits
// in its final step until that register is free. Register writes are always taken.
module linear_times_rbf_kernel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltrk_in_if.sink     i_in,
    ltrk_out_if.source  o_out,
    ltrk_cfg_if.sink    i_cfg
);

    ltrk_pkg::t_dp_cmd  w_cmd;
    ltrk_pkg::t_dp_stat w_stat;
    logic               w_in_ready;

    // The controller steps through the back end once per pair; the datapath holds all
    // arithmetic and the result register.
    ltrk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_last     (i_in.last),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ltrk_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_x_elem       (i_in.x_elem),
        .i_y_elem       (i_in.y_elem),
        .i_p_elem       (i_in.p_elem),
        .i_q_elem       (i_in.q_elem),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kernel_value (o_out.kernel_value),
        .o_saturated    (o_out.saturated)
    );

    assign i_in.ready  = w_in_ready;
    // Register writes complete in the cycle they are offered.
    assign i_cfg.ready = 1'b1;

endmodule
